// ----- rtl/core/fnp_pkg.sv -----
// ---------------------------------------------------------------------------
// fnp_pkg - shared types and codes of the node pool
// Command and status codes, the node word layout and memory control flags.
// ---------------------------------------------------------------------------
`default_nettype none

package fnp_pkg;

  localparam int unsigned LINK_W = 11;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned ADDR_W = 10;

  localparam logic [LINK_W-1:0] LINK_NONE = 11'h7FF;
  localparam logic [LINK_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_PUT    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_e;

  // One entry of the link memory.
  typedef struct packed {
    logic [LINK_W-1:0] left_lnk;
    logic [LINK_W-1:0] right_lnk;
    logic              in_use;
  } node_t;

  // Write strobes from the command engine to the two memories.
  typedef struct packed {
    logic node_we;
    logic key_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/fnp_if.sv -----
// ---------------------------------------------------------------------------
// fnp_if - command and response channels of the node pool
// Valid/ready channels; a word moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface fnp_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [9:0]         node_addr;
  logic signed [31:0] node_key;
  logic signed [10:0] left_link;
  logic signed [10:0] right_link;

  modport source (output valid, command, node_addr, node_key, left_link, right_link,
                  input ready);
  modport sink   (input valid, command, node_addr, node_key, left_link, right_link,
                  output ready);
endinterface

interface fnp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] result_addr;
  logic signed [31:0] read_key;
  logic signed [10:0] read_left;
  logic signed [10:0] read_right;
  logic [1:0]         status;

  modport source (output valid, result_addr, read_key, read_left, read_right, status,
                  input ready);
  modport sink   (input valid, result_addr, read_key, read_left, read_right, status,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/free_list_node_pool.sv -----
// A command word is accepted and its entry (the free head for a create) read out of
// the link memory; the engine then modifies it, writes it back and registers the
// response word once the response channel can take it. A new command is taken only
// after the previous one is answered: the registered read of the link memory and its
// write-back come before the next command may read it. Reset and every pool_size write
// rebuild the free chain (1024 entries after reset); input is not ready meanwhile.
// ---------------------------------------------------------------------------
// free_list_node_pool - fixed pool of tree nodes with a threaded free list
// Create, delete, get and put on a node memory; free entries chained through
// their left links, popped and pushed at the head.
// ---------------------------------------------------------------------------
`default_nettype none

module free_list_node_pool
  import fnp_pkg::*;
#(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [LINK_W-1:0] cfg_data,
  fnp_cmd_if.sink                cmd,
  fnp_rsp_if.source              rsp
);

  localparam int AW = $clog2(POOL_DEPTH);

  // Pool size register; the value in effect is clamped to 1..POOL_DEPTH.
  logic [LINK_W-1:0] pool_size;
  logic [LINK_W-1:0] size;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= CFG_RESET;
    end else if (cfg_we) begin
      pool_size <= cfg_data;
    end
  end

  always_comb begin
    if (pool_size == '0) begin
      size = LINK_W'(1);
    end else if (32'(pool_size) > POOL_DEPTH) begin
      size = LINK_W'(POOL_DEPTH);
    end else begin
      size = pool_size;
    end
  end

  // Rebuild sweep: owns the link memory write port while busy.
  logic          clr_busy;
  logic          clr_we;
  logic [AW-1:0] clr_addr;
  node_t         clr_data;

  fnp_clear #(.POOL_DEPTH(POOL_DEPTH)) u_clear (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .size    (size),
    .busy    (clr_busy),
    .wr_en   (clr_we),
    .wr_addr (clr_addr),
    .wr_data (clr_data)
  );

  // Command engine: read, modify, write back, answer.
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    eng_addr;
  mem_ctl_t         eng_ctl;
  node_t            eng_node;
  logic [KEY_W-1:0] eng_key;
  node_t            node_rdata;
  logic [KEY_W-1:0] key_rdata;

  fnp_engine #(.POOL_DEPTH(POOL_DEPTH)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .size       (size),
    .busy       (clr_busy),
    .cmd        (cmd),
    .rsp        (rsp),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr_addr    (eng_addr),
    .ctl        (eng_ctl),
    .node_wdata (eng_node),
    .key_wdata  (eng_key),
    .node_rdata (node_rdata),
    .key_rdata  (key_rdata)
  );

  // Link memory: left link, right link and in-use mark per entry.
  logic                     node_we;
  logic [AW-1:0]            node_waddr;
  logic [$bits(node_t)-1:0] node_wword;
  logic [$bits(node_t)-1:0] node_rword;

  assign node_we    = clr_busy ? clr_we   : eng_ctl.node_we;
  assign node_waddr = clr_busy ? clr_addr : eng_addr;
  assign node_wword = clr_busy ? clr_data : eng_node;
  assign node_rdata = node_t'(node_rword);

  fnp_ram #(.WIDTH($bits(node_t)), .DEPTH(POOL_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wword),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (node_rword)
  );

  // Key memory: never cleared; a key is returned only from an entry in use, and
  // every successful create writes its key.
  fnp_ram #(.WIDTH(KEY_W), .DEPTH(POOL_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (eng_ctl.key_we),
    .waddr (eng_addr),
    .wdata (eng_key),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/fnp_ram.sv -----
// ---------------------------------------------------------------------------
// fnp_ram - generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fnp_clear.sv -----
// ---------------------------------------------------------------------------
// fnp_clear - free chain rebuild sweep
// Walks the active entries once after reset or a size write, one per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module fnp_clear
  import fnp_pkg::*;
#(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [LINK_W-1:0]             size,
  output logic                               busy,
  output logic                               wr_en,
  output logic [$clog2(POOL_DEPTH)-1:0]      wr_addr,
  output node_t                              wr_data
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = (AW > LINK_W) ? AW : LINK_W;

  logic [AW-1:0] idx;
  logic          last;

  assign last = (CW'(idx) == (CW'(size) - CW'(1)));

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + AW'(1);
      end
    end
  end

  // Chain each entry to the next; the last active one ends the list.
  always_comb begin
    wr_en             = busy;
    wr_addr           = idx;
    wr_data.left_lnk  = last ? LINK_NONE : LINK_W'(CW'(idx) + CW'(1));
    wr_data.right_lnk = LINK_NONE;
    wr_data.in_use    = 1'b0;
  end

endmodule

`default_nettype wire

// ----- rtl/core/fnp_engine.sv -----
// ---------------------------------------------------------------------------
// fnp_engine - command engine of the node pool
// Reads the entry or free head; writes back on create, delete, put; answers.
// ---------------------------------------------------------------------------
`default_nettype none

module fnp_engine
  import fnp_pkg::*;
#(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [LINK_W-1:0]         size,
  input  wire logic                      busy,
  fnp_cmd_if.sink                        cmd,
  fnp_rsp_if.source                      rsp,
  output logic                           rd_en,
  output logic [$clog2(POOL_DEPTH)-1:0]  rd_addr,
  output logic [$clog2(POOL_DEPTH)-1:0]  wr_addr,
  output mem_ctl_t                       ctl,
  output node_t                          node_wdata,
  output logic [KEY_W-1:0]               key_wdata,
  input  wire node_t                     node_rdata,
  input  wire logic [KEY_W-1:0]          key_rdata
);

  localparam int AW = $clog2(POOL_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t              state;
  cmd_e                op;
  logic [ADDR_W-1:0]   addr_q;
  logic [KEY_W-1:0]    key_q;
  logic [LINK_W-1:0]   lft_q;
  logic [LINK_W-1:0]   rgt_q;
  logic [LINK_W-1:0]   free_head;
  logic [LINK_W-1:0]   free_head_next;
  logic [LINK_W-1:0]   used_count;
  logic [LINK_W-1:0]   used_count_next;

  logic                rsp_valid;
  logic [LINK_W-1:0]   rsp_addr;
  logic [KEY_W-1:0]    rsp_key;
  logic [LINK_W-1:0]   rsp_left;
  logic [LINK_W-1:0]   rsp_right;
  status_e             rsp_status;

  logic [LINK_W-1:0]   res_addr;
  logic [KEY_W-1:0]    res_key;
  logic [LINK_W-1:0]   res_left;
  logic [LINK_W-1:0]   res_right;
  status_e             res_status;

  logic                accept;
  logic                complete;
  logic                create_ok;
  logic                range_bad;

  assign accept   = cmd.valid && cmd.ready;
  assign complete = (state == S_EXEC) && (!rsp_valid || rsp.ready);

  assign cmd.ready       = (state == S_IDLE) && !busy;
  assign rsp.valid       = rsp_valid;
  assign rsp.result_addr = rsp_addr;
  assign rsp.read_key    = rsp_key;
  assign rsp.read_left   = rsp_left;
  assign rsp.read_right  = rsp_right;
  assign rsp.status      = rsp_status;

  // Create reads the free head to learn its successor; others read their entry.
  assign rd_en   = accept;
  assign rd_addr = (cmd_e'(cmd.command) == CMD_CREATE) ? AW'(free_head) : AW'(cmd.node_addr);

  assign create_ok = (used_count != size) && !free_head[LINK_W-1] && (free_head < size);
  assign range_bad = ({1'b0, addr_q} >= size);

  always_comb begin
    free_head_next  = free_head;
    used_count_next = used_count;
    ctl             = '0;
    wr_addr         = AW'(addr_q);
    node_wdata      = node_rdata;
    key_wdata       = key_q;
    res_addr        = LINK_NONE;
    res_key         = '0;
    res_left        = LINK_NONE;
    res_right       = LINK_NONE;
    res_status      = ST_OK;

    if (op == CMD_CREATE) begin
      wr_addr = AW'(free_head);
      if (create_ok) begin
        free_head_next       = node_rdata.left_lnk;
        used_count_next      = used_count + LINK_W'(1);
        ctl.node_we          = complete;
        ctl.key_we           = complete;
        node_wdata.left_lnk  = lft_q;
        node_wdata.right_lnk = rgt_q;
        node_wdata.in_use    = 1'b1;
        res_addr             = free_head;
      end else begin
        res_status = ST_FULL;
      end
    end else if (range_bad) begin
      res_status = ST_RANGE;
    end else begin
      case (op)
        CMD_DELETE: begin
          // Push even when already free; the status only warns.
          if (!node_rdata.in_use) begin
            res_status = ST_FREE;
          end
          ctl.node_we          = complete;
          node_wdata.left_lnk  = free_head;
          node_wdata.right_lnk = LINK_NONE;
          node_wdata.in_use    = 1'b0;
          free_head_next       = LINK_W'(addr_q);
          used_count_next      = used_count - LINK_W'(1);
        end
        CMD_GET: begin
          if (node_rdata.in_use) begin
            res_key = key_rdata;
          end else begin
            res_status = ST_FREE;
          end
          res_left  = node_rdata.left_lnk;
          res_right = node_rdata.right_lnk;
        end
        CMD_PUT: begin
          // Overwrite links and key, keep the in-use mark.
          ctl.node_we          = complete;
          ctl.key_we           = complete;
          node_wdata.left_lnk  = lft_q;
          node_wdata.right_lnk = rgt_q;
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      free_head  <= '0;
      used_count <= '0;
    end else begin
      if (cfg_we) begin
        free_head  <= '0;
        used_count <= '0;
      end else if (complete) begin
        free_head  <= free_head_next;
        used_count <= used_count_next;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (complete) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (complete) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= cmd_e'(cmd.command);
      addr_q <= cmd.node_addr;
      key_q  <= cmd.node_key;
      lft_q  <= cmd.left_link;
      rgt_q  <= cmd.right_link;
    end
    if (complete) begin
      rsp_addr   <= res_addr;
      rsp_key    <= res_key;
      rsp_left   <= res_left;
      rsp_right  <= res_right;
      rsp_status <= res_status;
    end
  end

  // A successful create hands out the old free head and counts one more node.
  a_create_addr: assert property (@(posedge clk) disable iff (rst)
    (complete && op == CMD_CREATE && create_ok && !cfg_we)
      |=> (rsp_addr == $past(free_head)) && (used_count == $past(used_count) + LINK_W'(1)))
    else $error("create did not pop the free head");

  // A delete in range makes its entry the new free head.
  a_delete_head: assert property (@(posedge clk) disable iff (rst)
    (complete && op == CMD_DELETE && !range_bad && !cfg_we)
      |=> (free_head == LINK_W'($past(addr_q))))
    else $error("delete did not push onto the free list");

  // Memories are only written by the engine while an item is being finished.
  a_write_exec: assert property (@(posedge clk) disable iff (rst)
    (ctl.node_we || ctl.key_we) |-> complete)
    else $error("memory write outside command completion");

  // Nothing is taken in while the free chain is being rebuilt.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept && (state == S_IDLE || !ctl.node_we))
    else $error("command accepted during rebuild");

endmodule

`default_nettype wire
